[sv/ufd_pkg.sv]
`timescale 1ns / 1ps

package ufd_pkg;

  localparam int CLOCK_W   = 28;
  localparam int BAUD_W    = 22;
  localparam int DL_W      = 28;
  localparam int QUOT_W    = 33;
  localparam int DIVR_W    = 37;
  localparam int NIBBLE_W  = 4;

  localparam logic [CLOCK_W-1:0]  CLOCK_RESET = 28'd12000000;
  localparam logic [7:0]          FRAC_EXACT  = 8'h10;
  localparam logic [NIBBLE_W-1:0] DV_FIRST    = 4'd1;
  localparam logic [NIBBLE_W-1:0] DV_LAST     = 4'd14;
  localparam logic [NIBBLE_W-1:0] MV_LAST     = 4'd15;
  localparam logic [QUOT_W-1:0]   DL_MIN      = 33'd3;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAUD_HIGH = 2'd1,
    ERR_DL_WIDE   = 2'd2
  } err_code_t;

endpackage

[sv/uart_fractional_divider_search_unit.sv]
`timescale 1ns / 1ps

// channel   dir  signals                        contents
// s_axis    in   tvalid tready tdata[23:0]      baud_rate[21:0]
// m_axis    out  tvalid tready tdata[31:0]      divisor[15:0] fraction_setting[23:16]
//                                               error_code[25:24]
// cfg       in   cfg_we cfg_wdata[27:0]         clock_hz
//
// Every rounded divisor and every rate goes through one shared restoring divider. Each
// fraction pair takes up to two divisions; there are 105 pairs at most. An exact rate
// or a zero divisor finishes after the first division, and a zero baud rate goes
// straight to the output state.
// Synchronous reset sets clock_hz to 12 MHz and clears all handshakes.
// The input is taken only while idle; a finished result sits in the output register
// and the next request may be accepted while it waits. A second finished result holds
// until the first one has been taken.

module uart_fractional_divider_search_unit import ufd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // baud_rate[21:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // divisor, fraction_setting, error_code
  input  logic               cfg_we,
  input  logic [CLOCK_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DL0,
    ST_WAIT_DL0,
    ST_WAIT_ERR0,
    ST_PAIR_MUL,
    ST_PAIR_DIV,
    ST_WAIT_DL,
    ST_RATE_MUL,
    ST_WAIT_RATE,
    ST_ADVANCE,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

  state_t                state;
  logic [CLOCK_W-1:0]    clock_hz;
  logic [BAUD_W-1:0]     br;
  logic [NIBBLE_W-1:0]   dv;
  logic [NIBBLE_W-1:0]   mv;
  logic [4:0]            sum;
  logic [31:0]           clk_mv;
  logic [30:0]           pair_den;
  logic [DL_W-1:0]       dl;
  logic [DL_W-1:0]       best_dl;
  logic [QUOT_W-1:0]     best_err;
  logic [7:0]            best_frac;
  logic [15:0]           res_div;
  logic [7:0]            res_frac;
  err_code_t             res_err;
  logic                  div_start;
  logic [QUOT_W-1:0]     div_num;
  logic [DIVR_W-1:0]     div_den;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;
  logic [DIVR_W-1:0]     div_rem;
  logic [QUOT_W-1:0]     err_now;
  logic [QUOT_W-1:0]     br_ext;

  ufd_divider #(
    .NUM_W (QUOT_W),
    .DEN_W (DIVR_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .numer  (div_num),
    .denom  (div_den),
    .done   (div_done),
    .quot   (div_quot),
    .remain (div_rem)
  );

  always_comb begin
    sum     = {1'b0, mv} + {1'b0, dv};
    br_ext  = {{(QUOT_W-BAUD_W){1'b0}}, br};
    err_now = (div_quot > br_ext) ? (div_quot - br_ext) : (br_ext - div_quot);
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz      <= CLOCK_RESET;
      state         <= ST_IDLE;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        clock_hz <= cfg_wdata;
      end
      // the output state reloads the register itself
      if (m_axis_tvalid && m_axis_tready && state != ST_OUTPUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            br <= s_axis_tdata[BAUD_W-1:0];
            if (s_axis_tdata[BAUD_W-1:0] == '0) begin
              res_div  <= '0;
              res_frac <= '0;
              res_err  <= ERR_DL_WIDE;
              state    <= ST_OUTPUT;
            end else begin
              state <= ST_DL0;
            end
          end
        end
        ST_DL0: begin
          // rounded divisor (clk + 8br) / 16br
          div_num   <= {4'b0, clock_hz} + {8'b0, br, 3'b0};
          div_den   <= {11'b0, br, 4'b0};
          div_start <= 1'b1;
          state     <= ST_WAIT_DL0;
        end
        ST_WAIT_DL0: begin
          if (div_done) begin
            dl        <= div_quot[DL_W-1:0];
            best_dl   <= div_quot[DL_W-1:0];
            best_frac <= FRAC_EXACT;
            if (div_quot == '0) begin
              res_div  <= '0;
              res_frac <= '0;
              res_err  <= ERR_BAUD_HIGH;
              state    <= ST_OUTPUT;
            end else if (div_rem == {12'b0, br, 3'b0}) begin
              // remainder of exactly 8br means 16*br*dl0 == clk
              state <= ST_FINISH;
            end else begin
              div_num   <= {5'b0, clock_hz};
              div_den   <= {5'b0, div_quot[DL_W-1:0], 4'b0};
              div_start <= 1'b1;
              state     <= ST_WAIT_ERR0;
            end
          end
        end
        ST_WAIT_ERR0: begin
          if (div_done) begin
            best_err <= err_now;
            dv       <= DV_FIRST;
            mv       <= DV_FIRST + 1'b1;
            state    <= ST_PAIR_MUL;
          end
        end
        ST_PAIR_MUL: begin
          clk_mv   <= {4'b0, clock_hz} * {28'b0, mv};
          pair_den <= {5'b0, br, 4'b0} * {26'b0, sum};
          state    <= ST_PAIR_DIV;
        end
        ST_PAIR_DIV: begin
          div_num   <= {1'b0, clk_mv} + {3'b0, pair_den[30:1]};
          div_den   <= {6'b0, pair_den};
          div_start <= 1'b1;
          state     <= ST_WAIT_DL;
        end
        ST_WAIT_DL: begin
          if (div_done) begin
            dl <= div_quot[DL_W-1:0];
            // skip divisors below three
            state <= (div_quot < DL_MIN) ? ST_ADVANCE : ST_RATE_MUL;
          end
        end
        ST_RATE_MUL: begin
          div_num   <= {1'b0, clk_mv};
          div_den   <= {5'b0, dl, 4'b0} * {32'b0, sum};
          div_start <= 1'b1;
          state     <= ST_WAIT_RATE;
        end
        ST_WAIT_RATE: begin
          if (div_done) begin
            if (err_now < best_err) begin
              best_err  <= err_now;
              best_dl   <= dl;
              best_frac <= {mv, dv};
            end
            state <= ST_ADVANCE;
          end
        end
        ST_ADVANCE: begin
          if (mv == MV_LAST) begin
            if (dv == DV_LAST) begin
              state <= ST_FINISH;
            end else begin
              dv    <= dv + 1'b1;
              mv    <= dv + 4'd2;
              state <= ST_PAIR_MUL;
            end
          end else begin
            mv    <= mv + 1'b1;
            state <= ST_PAIR_MUL;
          end
        end
        ST_FINISH: begin
          if (best_dl[DL_W-1:16] != '0) begin
            res_div  <= '0;
            res_frac <= '0;
            res_err  <= ERR_DL_WIDE;
          end else begin
            res_div  <= best_dl[15:0];
            res_frac <= best_frac;
            res_err  <= ERR_NONE;
          end
          state <= ST_OUTPUT;
        end
        ST_OUTPUT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {6'b0, res_err, res_frac, res_div};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/ufd_divider.sv]
`timescale 1ns / 1ps

module ufd_divider import ufd_pkg::*; #(
  parameter int NUM_W = QUOT_W,
  parameter int DEN_W = DIVR_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] remain
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, work[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        work  <= numer;
        rem   <= '0;
        den_r <= denom;
      end else if (busy) begin
        rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        work <= {work[NUM_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot   = work;
  assign remain = rem;

endmodule
